### design/xpc_pkg.sv
// xpc_pkg: shared types and constants for the xorshift pattern checker
// no dependencies; imported by every module of the checker
`default_nettype none

package xpc_pkg;

  // saturating counter width (16 to 64)
  localparam int CNT_W = 48;
  localparam int FIELD_W = 48;

  localparam logic [63:0] PATTERN_MULT = 64'h2545_F491_4F6C_DD1D;
  localparam logic [63:0] SEED_RESET = 64'h0000_0C0F_FEE1_2345;

  localparam int XS_A = 12;
  localparam int XS_B = 25;
  localparam int XS_C = 27;

  // register index codes of the configuration port
  typedef enum logic [1:0] {
    REG_SEED     = 2'd0,
    REG_VERIFY   = 2'd1,
    REG_EXPECTED = 2'd2
  } cfg_idx_t;

  // pattern generator sequencer
  typedef enum logic [2:0] {
    GEN_STEP,
    GEN_MUL_LL,
    GEN_MUL_LH,
    GEN_MUL_HL,
    GEN_PUSH
  } gen_state_t;

  // pattern words buffered ahead of the front stage
  localparam int WQ_DEPTH = 2;
  localparam int WQ_AW = $clog2(WQ_DEPTH);

  // item queue between front and back
  localparam int IQ_DEPTH = 4;
  localparam int IQ_AW = $clog2(IQ_DEPTH);

  typedef struct packed {
    logic ok;
  } item_t;

  typedef struct packed {
    logic restart;
    logic verify;
    logic [FIELD_W-1:0] expected;
  } ctl_t;

  function automatic logic [63:0] xs_step(input logic [63:0] v);
    logic [63:0] x;
    x = v;
    x = x ^ (x >> XS_A);
    x = x ^ (x << XS_B);
    x = x ^ (x >> XS_C);
    return x;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(input logic [CNT_W-1:0] v);
    logic [63:0] e;
    e = 64'(v);
    return e[FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

### design/xpc_pgen.sv
// xpc_pgen: xorshift64* pattern word generator with a short word queue
// depends on xpc_pkg; one shared 32x32 multiplier for the three partial products of each word
`default_nettype none

module xpc_pgen (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        restart,
  input  wire logic [63:0] new_seed,
  input  wire logic        word_pop,
  output logic             word_valid,
  output logic [63:0]      word
);
  import xpc_pkg::*;

  gen_state_t gstate, gstate_next;
  logic [63:0] x;
  logic [63:0] prod;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic [63:0]       wq [WQ_DEPTH];
  logic [WQ_AW-1:0]  wr_ptr, rd_ptr;
  logic [WQ_AW:0]    cnt;
  logic              wq_full, push;

  assign wq_full = (cnt == (WQ_AW+1)'(WQ_DEPTH));
  assign word_valid = (cnt != '0);
  assign word = wq[rd_ptr];
  assign push = (gstate == GEN_PUSH) && !wq_full;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    gstate_next = gstate;
    mul_a = x[31:0];
    mul_b = PATTERN_MULT[31:0];
    case (gstate)
      GEN_STEP:   gstate_next = GEN_MUL_LL;
      GEN_MUL_LL: gstate_next = GEN_MUL_LH;
      GEN_MUL_LH: begin
        mul_b = PATTERN_MULT[63:32];
        gstate_next = GEN_MUL_HL;
      end
      GEN_MUL_HL: begin
        mul_a = x[63:32];
        gstate_next = GEN_PUSH;
      end
      GEN_PUSH:   if (!wq_full) gstate_next = GEN_STEP;
      default:    gstate_next = GEN_STEP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gstate <= GEN_STEP;
      x <= SEED_RESET;
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else if (restart) begin
      gstate <= GEN_STEP;
      x <= new_seed;
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      gstate <= gstate_next;
      case (gstate)
        GEN_STEP:   x <= xs_step(x);
        GEN_MUL_LL: prod <= mul_p;
        GEN_MUL_LH: prod[63:32] <= prod[63:32] + mul_p[31:0];
        GEN_MUL_HL: prod[63:32] <= prod[63:32] + mul_p[31:0];
        default:    ;
      endcase
      if (push) begin
        wq[wr_ptr] <= prod;
        wr_ptr <= wr_ptr + WQ_AW'(1);
      end
      if (word_pop) rd_ptr <= rd_ptr + WQ_AW'(1);
      cnt <= cnt + (WQ_AW+1)'(push) - (WQ_AW+1)'(word_pop);
    end
  end

endmodule

`default_nettype wire

### design/xpc_front.sv
// xpc_front: accepts received bytes and compares them with the pattern
// depends on xpc_pkg; takes pattern words from xpc_pgen, feeds xpc_queue
`default_nettype none

module xpc_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire xpc_pkg::ctl_t ctl,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   data_byte,
  input  wire logic         word_valid,
  input  wire logic [63:0]  word_in,
  output logic              word_pop,
  input  wire logic         q_full,
  output logic              q_push,
  output xpc_pkg::item_t    q_item
);
  import xpc_pkg::*;

  logic [63:0] word;
  logic [3:0]  pos;
  logic        need_word, accept;
  logic [63:0] cur_word;
  logic [2:0]  cur_pos;
  logic [7:0]  exp_byte;

  // pos of eight means the held word is used up
  assign need_word = ctl.verify && pos[3];
  assign in_stall = q_full || (need_word && !word_valid);
  assign accept = in_valid && !in_stall;
  assign cur_word = need_word ? word_in : word;
  assign cur_pos = need_word ? 3'd0 : pos[2:0];
  assign exp_byte = cur_word[{cur_pos, 3'b000} +: 8];

  assign word_pop = accept && need_word;
  assign q_push = accept;
  assign q_item.ok = !ctl.verify || (data_byte == exp_byte);

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      pos <= 4'd8;
      word <= '0;
    end else if (accept && ctl.verify) begin
      word <= cur_word;
      pos <= {1'b0, cur_pos} + 4'd1;
    end
  end

endmodule

`default_nettype wire

### design/xpc_queue.sv
// xpc_queue: short item queue between the front and back stages
// depends on xpc_pkg for item_t and the queue depth
`default_nettype none

module xpc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire xpc_pkg::item_t push_item,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output xpc_pkg::item_t     head
);
  import xpc_pkg::*;

  item_t            mem [IQ_DEPTH];
  logic [IQ_AW-1:0] wr_ptr, rd_ptr;
  logic [IQ_AW:0]   cnt;

  assign full = (cnt == (IQ_AW+1)'(IQ_DEPTH));
  assign not_empty = (cnt != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + IQ_AW'(1);
      if (pop) rd_ptr <= rd_ptr + IQ_AW'(1);
      cnt <= cnt + (IQ_AW+1)'(push) - (IQ_AW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

### design/xpc_back.sv
// xpc_back: saturating byte and mismatch counters and the result register
// depends on xpc_pkg; drains items from xpc_queue
`default_nettype none

module xpc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire xpc_pkg::ctl_t ctl,
  input  wire logic          q_not_empty,
  input  wire xpc_pkg::item_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               byte_ok,
  output logic [xpc_pkg::FIELD_W-1:0] mismatch_count,
  output logic [xpc_pkg::FIELD_W-1:0] byte_count,
  output logic               done_res,
  output logic               pass
);
  import xpc_pkg::*;

  logic [CNT_W-1:0] rcv, mis;
  logic [CNT_W-1:0] rcv_next, mis_next;
  logic             done_next;

  assign q_pop = q_not_empty && (!out_valid || !out_stall);
  assign rcv_next = sat_inc(rcv);
  assign mis_next = q_head.ok ? mis : sat_inc(mis);
  assign done_next = 64'(rcv_next) >= 64'(ctl.expected);

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      rcv <= '0;
      mis <= '0;
    end else if (q_pop) begin
      rcv <= rcv_next;
      mis <= mis_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      byte_ok <= q_head.ok;
      mismatch_count <= to_field(mis_next);
      byte_count <= to_field(rcv_next);
      done_res <= done_next;
      pass <= done_next && (64'(rcv_next) == 64'(ctl.expected)) && (mis_next == '0);
    end
  end

endmodule

`default_nettype wire

### design/xorshift_pattern_checker.sv
// xorshift_pattern_checker: one byte per cycle while in_stall is low; the result for
// a taken byte passes the item queue, then the result register; the shared
// multiplier makes each pattern word ahead of the eight bytes that use it.
// reset or a seed write restarts the stream: the first verified byte waits
// for the first pattern word, counters start at zero.
`default_nettype none

module xorshift_pattern_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [63:0] wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             byte_ok,
  output logic [47:0]      mismatch_count,
  output logic [47:0]      byte_count,
  output logic             done_res,
  output logic             pass
);
  import xpc_pkg::*;

  logic               verify;
  logic [FIELD_W-1:0] expected;
  ctl_t               ctl;

  logic        word_valid, word_pop;
  logic [63:0] word;
  logic        q_full, q_push, q_pop, q_not_empty;
  item_t       q_item, q_head;

  assign ctl.restart = wr_en && (cfg_idx_t'(wr_index) == REG_SEED);
  assign ctl.verify = verify;
  assign ctl.expected = expected;

  always_ff @(posedge clk) begin
    if (rst) begin
      verify <= 1'b1;
      expected <= '0;
    end else if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        REG_VERIFY:   verify <= wr_data[0];
        REG_EXPECTED: expected <= wr_data[FIELD_W-1:0];
        default:      ;
      endcase
    end
  end

  xpc_pgen u_pgen (
    .clk        (clk),
    .rst        (rst),
    .restart    (ctl.restart),
    .new_seed   (wr_data),
    .word_pop   (word_pop),
    .word_valid (word_valid),
    .word       (word)
  );

  xpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .word_valid (word_valid),
    .word_in    (word),
    .word_pop   (word_pop),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_item)
  );

  xpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  xpc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .q_not_empty    (q_not_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .byte_ok        (byte_ok),
    .mismatch_count (mismatch_count),
    .byte_count     (byte_count),
    .done_res       (done_res),
    .pass           (pass)
  );

endmodule

`default_nettype wire
